@@ sv/bsa_pkg.sv @@
// Shared constants and types for the bucket slab allocator.
`default_nettype none
package bsa_pkg;

  localparam int unsigned NUM_CLASSES = 9;
  localparam int unsigned CLASS_W     = 4;
  localparam int unsigned SLOT_W      = 9;
  localparam logic [SLOT_W-1:0] SLOT_NONE = 9'd256;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_PAGES  = 2'd2,
    STATUS_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

endpackage
`default_nettype wire

@@ sv/bucket_slab_allocator_core.sv @@
// Bucket slab allocator: page descriptor memory, slot link memory and control sequencer.
`default_nettype none
// Power-of-two slab allocator over NUM_PAGES pages of 4096 bytes. A transaction is accepted
// when start is high and busy is low; its single result appears for one cycle with valid_o and
// cannot be stalled. Timing is set by the page descriptor memory, read once per chain hop.
// An allocate walks its class chain until it finds a page with a free slot and pops that slot.
// One that opens a new page takes it from the spare list and carves 256/(object size/16)
// slot links, one slot link a cycle, into the slot memory. A free steps through the classes
// from the size hint up, walks each chain in search of the page, and writes the predecessor
// descriptor back as well when the released page had a predecessor in its chain.
// No clearing pass follows reset.
module bucket_slab_allocator_core #(
  parameter int unsigned NUM_PAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode_i,
  input  wire logic [12:0] request_length_i,
  input  wire logic [15:0] free_address_i,
  input  wire logic [12:0] size_hint_i,
  output logic             valid_o,
  output logic [15:0]      object_address_o,
  output logic [1:0]       status_o
);

  localparam int unsigned LW = $clog2(NUM_PAGES + 1);
  localparam int unsigned IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW = bsa_pkg::CLASS_W;
  localparam int unsigned SW = bsa_pkg::SLOT_W;
  localparam logic [LW-1:0] PAGE_NONE = LW'(NUM_PAGES);

  typedef struct packed {
    logic [LW-1:0] nxt;
    logic [CW-1:0] cls;
    logic [SW-1:0] cnt;
    logic [SW-1:0] fh;
    logic [LW-1:0] spn;
  } pg_t;

  typedef enum logic [3:0] {
    S_IDLE, A_START, A_WALK, A_CHK, A_POP, A_NEW, A_SPARE, A_CARVE, A_LINK,
    F_CLS, F_STEP, F_NEXT, F_HIT, F_PREV
  } state_e;

  state_e         state_q, state_d;
  logic           op_q, op_d;
  logic [12:0]    len_q, len_d;
  logic [15:0]    addr_q, addr_d;
  logic [12:0]    hint_q, hint_d;
  logic [CW-1:0]  c_q, c_d;
  logic [LW-1:0]  p_q, p_d;
  logic [LW-1:0]  prev_q, prev_d;
  logic [LW-1:0]  guard_q, guard_d;
  logic [LW-1:0]  nxt_q, nxt_d;
  logic [SW-1:0]  i_q, i_d;
  logic [LW-1:0]  spare_q, spare_d;
  logic [LW-1:0]  head_q [bsa_pkg::NUM_CLASSES];
  logic [LW-1:0]  head_d [bsa_pkg::NUM_CLASSES];
  logic [NUM_PAGES-1:0] sv_q, sv_d;
  logic           valid_q, valid_d;
  logic [15:0]    res_addr_q, res_addr_d;
  logic [1:0]     res_status_q, res_status_d;

  pg_t            page_mem [NUM_PAGES];
  pg_t            pg_rd_q, pg_wdata;
  logic           pg_re, pg_we;
  logic [IW-1:0]  pg_raddr, pg_waddr;

  logic [SW-1:0]  slot_mem [NUM_PAGES*256];
  logic [SW-1:0]  sl_rd_q, sl_wdata;
  logic           sl_re, sl_we;
  logic [IW+7:0]  sl_raddr, sl_waddr;

  logic [CW-1:0]  len_cls;
  logic [12:0]    cur_size;
  logic [SW-1:0]  carve_n;
  logic [LW-1:0]  spn_eff;
  logic [CW-1:0]  hit_cls;
  logic [7:0]     hit_slot;
  logic [SW-1:0]  hit_cnt;
  logic [19:0]    pop_off;
  logic [15:0]    pop_addr;

  always_comb begin
    len_cls = CW'(bsa_pkg::NUM_CLASSES - 1);
    for (int k = bsa_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
      if ((13'd16 << k) >= len_q) len_cls = CW'(k);
    end
  end

  assign cur_size = 13'd16 << c_q;
  assign carve_n  = 9'd256 >> c_q;
  // Spare links not yet written follow the ascending order left by reset.
  assign spn_eff  = sv_q[pg_raddr] ? pg_rd_q.spn : p_q + LW'(1);
  assign hit_cls  = (pg_rd_q.cls < CW'(bsa_pkg::NUM_CLASSES)) ? pg_rd_q.cls : '0;
  assign hit_slot = 8'(addr_q[11:0] >> (hit_cls + CW'(4)));
  assign hit_cnt  = pg_rd_q.cnt - SW'(1);
  assign pop_off  = 20'({pg_rd_q.fh[7:0], 4'b0000}) << c_q;
  assign pop_addr = (16'(p_q) << 12) + pop_off[15:0];

  always_comb begin
    state_d = state_q; op_d = op_q; len_d = len_q; addr_d = addr_q; hint_d = hint_q;
    c_d = c_q; p_d = p_q; prev_d = prev_q; guard_d = guard_q; nxt_d = nxt_q; i_d = i_q;
    spare_d = spare_q; head_d = head_q; sv_d = sv_q;
    valid_d = 1'b0; res_addr_d = res_addr_q; res_status_d = res_status_q;
    pg_re = 1'b0; pg_raddr = p_q[IW-1:0];
    pg_we = 1'b0; pg_waddr = p_q[IW-1:0]; pg_wdata = pg_rd_q;
    sl_re = 1'b0; sl_raddr = {p_q[IW-1:0], pg_rd_q.fh[7:0]};
    sl_we = 1'b0; sl_waddr = {p_q[IW-1:0], i_q[7:0]}; sl_wdata = pg_rd_q.fh;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = opcode_i; len_d = request_length_i;
          addr_d = free_address_i; hint_d = size_hint_i;
          c_d = '0;
          if (opcode_i == bsa_pkg::OP_FREE) begin
            state_d = F_CLS;
          end else if (request_length_i > 13'd4096) begin
            valid_d = 1'b1; res_addr_d = '0; res_status_d = bsa_pkg::STATUS_TOO_LARGE;
          end else begin
            state_d = A_START;
          end
        end
      end
      A_START: begin
        c_d = len_cls;
        p_d = head_q[len_cls];
        guard_d = '0;
        state_d = A_WALK;
      end
      A_WALK: begin
        if (p_q >= PAGE_NONE || guard_q >= PAGE_NONE) begin
          state_d = A_NEW;
        end else begin
          pg_re = 1'b1;
          state_d = A_CHK;
        end
      end
      A_CHK: begin
        if (pg_rd_q.fh != bsa_pkg::SLOT_NONE) begin
          sl_re = 1'b1;
          state_d = A_POP;
        end else begin
          p_d = pg_rd_q.nxt;
          guard_d = guard_q + LW'(1);
          state_d = A_WALK;
        end
      end
      A_POP: begin
        pg_we = 1'b1;
        pg_wdata.fh  = sl_rd_q;
        pg_wdata.cnt = pg_rd_q.cnt + SW'(1);
        pg_wdata.spn = spn_eff;
        sv_d[p_q[IW-1:0]] = 1'b1;
        valid_d = 1'b1; res_addr_d = pop_addr; res_status_d = bsa_pkg::STATUS_OK;
        state_d = S_IDLE;
      end
      A_NEW: begin
        if (spare_q >= PAGE_NONE) begin
          valid_d = 1'b1; res_addr_d = '0; res_status_d = bsa_pkg::STATUS_NO_PAGES;
          state_d = S_IDLE;
        end else begin
          p_d = spare_q;
          pg_re = 1'b1; pg_raddr = spare_q[IW-1:0];
          i_d = '0;
          state_d = A_SPARE;
        end
      end
      A_SPARE: begin
        spare_d = spn_eff;
        state_d = A_CARVE;
      end
      A_CARVE: begin
        sl_we = 1'b1;
        sl_wdata = (i_q + SW'(1) < carve_n) ? i_q + SW'(1) : bsa_pkg::SLOT_NONE;
        i_d = i_q + SW'(1);
        if (i_q + SW'(1) == carve_n) state_d = A_LINK;
      end
      A_LINK: begin
        pg_we = 1'b1;
        pg_wdata.nxt = head_q[c_q];
        pg_wdata.cls = c_q;
        pg_wdata.cnt = SW'(1);
        pg_wdata.fh  = (c_q < CW'(bsa_pkg::NUM_CLASSES - 1)) ? SW'(1) : bsa_pkg::SLOT_NONE;
        pg_wdata.spn = spn_eff;
        sv_d[p_q[IW-1:0]] = 1'b1;
        head_d[c_q] = p_q;
        valid_d = 1'b1; res_addr_d = 16'(p_q) << 12; res_status_d = bsa_pkg::STATUS_OK;
        state_d = S_IDLE;
      end
      F_CLS: begin
        if (c_q == CW'(bsa_pkg::NUM_CLASSES)) begin
          valid_d = 1'b1; res_addr_d = '0; res_status_d = bsa_pkg::STATUS_BAD_FREE;
          state_d = S_IDLE;
        end else if (cur_size < hint_q) begin
          c_d = c_q + CW'(1);
        end else begin
          p_d = head_q[c_q];
          prev_d = PAGE_NONE;
          guard_d = '0;
          state_d = F_STEP;
        end
      end
      F_STEP: begin
        if (p_q >= PAGE_NONE || guard_q >= PAGE_NONE) begin
          c_d = c_q + CW'(1);
          state_d = F_CLS;
        end else begin
          pg_re = 1'b1;
          state_d = (16'(p_q) == 16'(addr_q[15:12])) ? F_HIT : F_NEXT;
        end
      end
      F_NEXT: begin
        prev_d = p_q;
        p_d = pg_rd_q.nxt;
        guard_d = guard_q + LW'(1);
        state_d = F_STEP;
      end
      F_HIT: begin
        sl_we = 1'b1;
        sl_waddr = {p_q[IW-1:0], hit_slot};
        sl_wdata = pg_rd_q.fh;
        nxt_d = pg_rd_q.nxt;
        pg_we = 1'b1;
        pg_wdata.fh  = SW'(hit_slot);
        pg_wdata.cnt = hit_cnt;
        pg_wdata.spn = spn_eff;
        sv_d[p_q[IW-1:0]] = 1'b1;
        valid_d = 1'b1; res_addr_d = '0; res_status_d = bsa_pkg::STATUS_OK;
        state_d = S_IDLE;
        if (hit_cnt == '0) begin
          // The page is empty: push it on the spare list and unlink it from its chain.
          pg_wdata.spn = spare_q;
          spare_d = p_q;
          if (prev_q < PAGE_NONE) begin
            pg_re = 1'b1; pg_raddr = prev_q[IW-1:0];
            p_d = prev_q;
            valid_d = 1'b0;
            state_d = F_PREV;
          end else begin
            head_d[hit_cls] = pg_rd_q.nxt;
          end
        end
      end
      F_PREV: begin
        pg_we = 1'b1;
        pg_wdata.nxt = nxt_q;
        pg_wdata.spn = spn_eff;
        sv_d[p_q[IW-1:0]] = 1'b1;
        valid_d = 1'b1; res_addr_d = '0; res_status_d = bsa_pkg::STATUS_OK;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      spare_q <= '0;
      for (int k = 0; k < bsa_pkg::NUM_CLASSES; k++) head_q[k] <= PAGE_NONE;
      sv_q    <= '0;
      valid_q <= 1'b0;
      c_q     <= '0;
      p_q     <= '0;
      prev_q  <= '0;
      guard_q <= '0;
      i_q     <= '0;
      op_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      spare_q <= spare_d;
      head_q  <= head_d;
      sv_q    <= sv_d;
      valid_q <= valid_d;
      c_q     <= c_d;
      p_q     <= p_d;
      prev_q  <= prev_d;
      guard_q <= guard_d;
      i_q     <= i_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    addr_q       <= addr_d;
    hint_q       <= hint_d;
    nxt_q        <= nxt_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) page_mem[pg_waddr] <= pg_wdata;
    if (pg_re) pg_rd_q <= page_mem[pg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) slot_mem[sl_waddr] <= sl_wdata;
    if (sl_re) sl_rd_q <= slot_mem[sl_raddr];
  end

  assign busy             = (state_q != S_IDLE);
  assign valid_o          = valid_q;
  assign object_address_o = res_addr_q;
  assign status_o         = res_status_q;

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(busy) || $past(start))
    else $error("result strobe without a transaction in progress");
  a_guard_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_q <= PAGE_NONE)
    else $error("chain walk ran past the page count");
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pg_we && pg_re && pg_waddr == pg_raddr))
    else $error("descriptor read and write collide on one entry");
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy || valid_o)
    else $error("accepted transaction neither started nor finished");
  a_free_no_alloc_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && op_q == bsa_pkg::OP_FREE) |->
      (res_status_q == bsa_pkg::STATUS_OK || res_status_q == bsa_pkg::STATUS_BAD_FREE))
    else $error("free reported an allocate status");
`endif

endmodule
`default_nettype wire

@@ tb/bucket_slab_allocator_core_tb.sv @@
// Self-checking testbench for the bucket slab allocator core.
`default_nettype none
module bucket_slab_allocator_core_tb;

  localparam int unsigned NPAGES = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef enum logic {
    REQ_FIXED,
    REQ_FREE_LIVE
  } req_kind_e;

  typedef struct {
    req_kind_e        kind;
    bsa_pkg::opcode_e op;
    logic [12:0]      len;
    logic [15:0]      addr;
    logic [12:0]      hint;
  } alloc_req_t;

  typedef struct {
    logic [15:0]      addr;
    bsa_pkg::status_e status;
  } alloc_resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [12:0] request_length_i;
  logic [15:0] free_address_i;
  logic [12:0] size_hint_i;
  logic        valid_o;
  logic [15:0] object_address_o;
  logic [1:0]  status_o;

  bucket_slab_allocator_core #(
    .NUM_PAGES(NPAGES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .request_length_i(request_length_i),
    .free_address_i  (free_address_i),
    .size_hint_i     (size_hint_i),
    .valid_o         (valid_o),
    .object_address_o(object_address_o),
    .status_o        (status_o)
  );

  // Shadow allocator state; page links use NPAGES for an empty link.
  logic [4:0] chain_head[bsa_pkg::NUM_CLASSES];
  logic [4:0] chain_link[NPAGES];
  logic [4:0] spare_head;
  logic [4:0] spare_link[NPAGES];
  logic [3:0] page_cls[NPAGES];
  logic [8:0] page_users[NPAGES];
  logic [8:0] page_free_slot[NPAGES];
  logic [8:0] slot_link[NPAGES*256];

  alloc_req_t  pending_reqs[$];
  alloc_resp_t expected_resps[$];
  logic [15:0] live_addrs[$];
  int unsigned live_sizes[$];

  int unsigned error_count;
  int unsigned accepted_count;
  int unsigned idle_cycles;
  bit          drain_done;

  function automatic int unsigned obj_size(int unsigned c);
    return 16 << c;
  endfunction

  function automatic alloc_resp_t apply_request(alloc_req_t r);
    alloc_resp_t res;
    int unsigned c, g, p, prev, slot, n, tgt, sz;
    bit found;
    res.addr = '0;
    res.status = bsa_pkg::STATUS_OK;
    if (r.op == bsa_pkg::OP_ALLOC) begin
      if (r.len > 4096) begin
        res.status = bsa_pkg::STATUS_TOO_LARGE;
        return res;
      end
      c = 0;
      while (c < bsa_pkg::NUM_CLASSES - 1 && obj_size(c) < r.len) c++;
      sz = obj_size(c);
      p = chain_head[c];
      for (g = 0; p < NPAGES && g < NPAGES; g++) begin
        if (page_free_slot[p] != bsa_pkg::SLOT_NONE) break;
        p = chain_link[p];
      end
      if (p >= NPAGES || g >= NPAGES) begin
        p = spare_head;
        if (p >= NPAGES) begin
          res.status = bsa_pkg::STATUS_NO_PAGES;
          return res;
        end
        spare_head = spare_link[p];
        page_users[p] = '0;
        page_cls[p] = c[3:0];
        n = 4096 / sz;
        for (int unsigned i = 0; i < n; i++)
          slot_link[p*256+i] = (i + 1 < n) ? 9'(i + 1) : bsa_pkg::SLOT_NONE;
        page_free_slot[p] = '0;
        chain_link[p] = chain_head[c];
        chain_head[c] = p[4:0];
      end
      slot = page_free_slot[p] & 255;
      page_free_slot[p] = slot_link[p*256+slot];
      page_users[p] = page_users[p] + 9'd1;
      res.addr = 16'(p * 4096 + slot * sz);
      live_addrs.push_back(res.addr);
      live_sizes.push_back(sz);
      return res;
    end
    tgt = r.addr >> 12;
    found = 0;
    p = NPAGES;
    prev = NPAGES;
    for (c = 0; c < bsa_pkg::NUM_CLASSES && !found; c++) begin
      if (obj_size(c) < r.hint) continue;
      prev = NPAGES;
      p = chain_head[c];
      for (g = 0; p < NPAGES && g < NPAGES; g++) begin
        if (p == tgt) begin
          found = 1;
          break;
        end
        prev = p;
        p = chain_link[p];
      end
    end
    if (!found) begin
      res.status = bsa_pkg::STATUS_BAD_FREE;
      return res;
    end
    c = (page_cls[p] < bsa_pkg::NUM_CLASSES) ? page_cls[p] : 0;
    slot = ((r.addr & 16'h0fff) / obj_size(c)) & 255;
    slot_link[p*256+slot] = page_free_slot[p];
    page_free_slot[p] = slot[8:0];
    page_users[p] = page_users[p] - 9'd1;
    if (page_users[p] == 0) begin
      if (prev < NPAGES) chain_link[prev] = chain_link[p];
      else chain_head[c] = chain_link[p];
      spare_link[p] = spare_head;
      spare_head = p[4:0];
    end
    return res;
  endfunction

  function automatic alloc_req_t make_fixed(bsa_pkg::opcode_e op, int unsigned len,
                                            int unsigned addr, int unsigned hint);
    alloc_req_t r;
    r.kind = REQ_FIXED;
    r.op = op;
    r.len = 13'(len);
    r.addr = 16'(addr);
    r.hint = 13'(hint);
    return r;
  endfunction

  function automatic alloc_req_t make_live_free();
    alloc_req_t r;
    r = make_fixed(bsa_pkg::OP_FREE, $urandom, 0, 0);
    r.kind = REQ_FREE_LIVE;
    return r;
  endfunction

  // Turns a free of a live object into concrete fields, using the state as it stands now.
  function automatic alloc_req_t resolve(alloc_req_t r);
    int unsigned k, sz;
    if (r.kind != REQ_FREE_LIVE) return r;
    if (live_addrs.size() == 0) begin
      r.addr = 16'($urandom);
      r.hint = 13'($urandom_range(0, 8191));
      return r;
    end
    k = $urandom_range(0, live_addrs.size() - 1);
    sz = live_sizes[k];
    r.addr = live_addrs[k] + 16'($urandom_range(0, sz - 1) & ((($urandom_range(0, 3)) == 0) ?
             32'hffff : 32'h0));
    // An occasional double free leaves the address on the list.
    if ($urandom_range(0, 49) != 0) begin
      live_addrs.delete(k);
      live_sizes.delete(k);
    end
    case ($urandom_range(0, 5))
      0, 1: r.hint = '0;
      2: r.hint = 13'(sz);
      3: r.hint = 13'($urandom_range(1, sz));
      4: r.hint = 13'($urandom_range(0, 8191));
      default: r.hint = 13'($urandom_range(0, sz));
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: a transaction is taken at an edge where start is high and busy is low.
  always @(posedge clk_i) begin
    alloc_req_t nxt;
    alloc_resp_t res;
    bit accepted;
    bit no_gaps;
    if (rst_ni) begin
      accepted = start && !busy;
      if (accepted) begin
        res = apply_request(make_fixed(bsa_pkg::opcode_e'(opcode_i), request_length_i,
                                       free_address_i, size_hint_i));
        expected_resps.push_back(res);
        accepted_count++;
      end
      no_gaps = accepted_count >= 300 && accepted_count < 500;
      if (!start || accepted) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
          nxt = resolve(pending_reqs.pop_front());
          opcode_i <= nxt.op;
          request_length_i <= nxt.len;
          free_address_i <= nxt.addr;
          size_hint_i <= nxt.hint;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked as it arrives.
  always @(posedge clk_i) begin
    alloc_resp_t exp_r;
    if (rst_ni && valid_o) begin
      if (expected_resps.size() == 0) begin
        $error("Result with nothing expected: object_address %h status %0d",
               object_address_o, status_o);
        error_count++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (object_address_o !== exp_r.addr) begin
          $error("object_address: expected %h, actual %h", exp_r.addr, object_address_o);
          error_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction and no result is taken.
  always @(posedge clk_i) begin
    if (!rst_ni || drain_done || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_allocs;
    int unsigned sz;
    start = 1'b0;
    opcode_i = bsa_pkg::OP_ALLOC;
    request_length_i = '0;
    free_address_i = '0;
    size_hint_i = '0;
    error_count = 0;
    accepted_count = 0;
    idle_cycles = 0;
    drain_done = 0;
    for (int i = 0; i < bsa_pkg::NUM_CLASSES; i++) chain_head[i] = 5'(NPAGES);
    for (int i = 0; i < NPAGES; i++) begin
      spare_link[i] = 5'(i + 1);
      chain_link[i] = '0;
      page_cls[i] = '0;
      page_users[i] = '0;
      page_free_slot[i] = '0;
    end
    for (int i = 0; i < NPAGES * 256; i++) slot_link[i] = '0;
    spare_head = '0;

    // Directed: zero and boundary lengths, oversize requests, frees that miss, frees of live objects.
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 0, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 1, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 16, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 17, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 2049, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 4096, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 4097, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, 8191, 0, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, 16'hffff, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, 16'h9000, 0));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, 16'h0000, 8191));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, 16'h0010, 4097));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, 16'h0010, 32));
    pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, 16'h1007, 16));
    pending_reqs.push_back(make_live_free());
    pending_reqs.push_back(make_live_free());
    for (int i = 0; i < 5; i++) pending_reqs.push_back(make_live_free());

    // Random phases alternate between filling the pool, which runs it out of pages,
    // and draining it, so pages are released and reused under other classes.
    for (int ph = 0; ph < 20; ph++) begin
      phase_allocs = (ph % 2 == 0) ? 75 : 30;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          if ($urandom_range(0, 1) != 0)
            pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, $urandom_range(0, 8191),
                                              0, 0));
          else
            pending_reqs.push_back(make_fixed(bsa_pkg::OP_FREE, 0, $urandom,
                                              $urandom_range(0, 8191)));
        end else if ($urandom_range(0, 99) < phase_allocs) begin
          sz = 16 << $urandom_range(0, 8);
          if ($urandom_range(0, 3) == 0) sz = 16 << $urandom_range(6, 8);
          pending_reqs.push_back(make_fixed(bsa_pkg::OP_ALLOC, $urandom_range(sz / 2, sz),
                                            0, 0));
        end else begin
          pending_reqs.push_back(make_live_free());
        end
      end
    end

    wait (rst_ni);
    while (pending_reqs.size() != 0 || start || expected_resps.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    drain_done = 1;
    if (error_count == 0 && expected_resps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
